[rtl/xcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcs_pkg
// shared types, constants, the crc step and the block range check of the xmodem-crc sender
// ----------------------------------------------------------------------------
package xcs_pkg;

  localparam int SizeBits   = 24;
  localparam int BlkBits    = 18;
  localparam int BlkShift   = 7;
  localparam int ByteOffs   = BlkBits + BlkShift;
  localparam int CmpBits    = (ByteOffs > SizeBits) ? ByteOffs : SizeBits;
  localparam int QueueDepth = 4;

  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [7:0] RxStart = 8'h43;
  localparam logic [7:0] RxAck   = 8'h06;
  localparam logic [7:0] RxNak   = 8'h15;
  localparam logic [7:0] TxSoh   = 8'h01;
  localparam logic [7:0] TxEot   = 8'h04;

  localparam logic ModeRx   = 1'b0;
  localparam logic ModeData = 1'b1;

  typedef enum logic [2:0] {
    JOB_ECHO,
    JOB_ECHO_CRC,
    JOB_FINISH,
    JOB_HEADER,
    JOB_EOT
  } job_kind_e;

  // one queued job: expands into one or three result items
  typedef struct packed {
    job_kind_e          kind;
    logic [7:0]         byte_val;
    logic [15:0]        crc;
    logic [BlkBits-1:0] blk;
  } job_t;

  // crc-16 over one byte, msb first, eight unrolled shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // true when block blk starts before the end of a file of size bytes
  function automatic logic blk_in_file(input logic [BlkBits-1:0] blk,
                                       input logic [SizeBits-1:0] size);
    logic [CmpBits-1:0] offs;
    logic [CmpBits-1:0] lim;
    offs = CmpBits'({blk, {BlkShift{1'b0}}});
    lim  = CmpBits'(size);
    return offs < lim;
  endfunction

endpackage
`default_nettype wire

[rtl/xcs_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcs_in_if
// input channel: receiver bytes and host payload bytes
// ----------------------------------------------------------------------------
interface xcs_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;
  logic [7:0] data_byte;

  modport source (output valid, mode, rx_byte, data_byte, input ready);
  modport sink   (input valid, mode, rx_byte, data_byte, output ready);
endinterface
`default_nettype wire

[rtl/xcs_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcs_out_if
// output channel: link bytes and host fetch requests
// ----------------------------------------------------------------------------
interface xcs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tx_byte;
  logic        send;
  logic        fetch_request;
  logic [17:0] fetch_block;
  logic        finished;
  logic        last;

  modport source (output valid, tx_byte, send, fetch_request, fetch_block, finished, last,
                  input ready);
  modport sink   (input valid, tx_byte, send, fetch_request, fetch_block, finished, last,
                  output ready);
endinterface
`default_nettype wire

[rtl/xcs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcs_front
// accepts items, updates session state and queues at most one job per item
// ----------------------------------------------------------------------------
module xcs_front import xcs_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [SizeBits-1:0] file_size_i,
  xcs_in_if.sink                   in_i,
  input  wire logic                queue_full_i,
  output      logic                push_o,
  output      job_t                job_o
);

  logic [BlkBits-1:0] last_block_q, last_block_d;
  logic [15:0]        crc_q, crc_d;
  logic [7:0]         count_q, count_d;
  logic               in_payload_q, in_payload_d;

  logic               accept;
  logic               want_push;
  logic [15:0]        crc_next;
  logic [7:0]         count_next;
  logic [BlkBits-1:0] blk;

  assign in_i.ready = !queue_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign crc_next   = crc_byte(crc_q, in_i.data_byte);
  assign count_next = count_q + 8'd1;
  assign push_o     = accept && want_push;

  always_comb begin
    last_block_d = last_block_q;
    crc_d        = crc_q;
    count_d      = count_q;
    in_payload_d = in_payload_q;
    want_push    = 1'b0;
    blk          = '0;
    job_o        = '{kind: JOB_ECHO, byte_val: in_i.data_byte, crc: crc_next, blk: '0};
    if (in_i.mode == ModeData) begin
      if (in_payload_q) begin
        want_push = 1'b1;
        crc_d     = crc_next;
        count_d   = count_next;
        // 128th byte closes the block
        if (count_next[7]) begin
          job_o.kind   = JOB_ECHO_CRC;
          in_payload_d = 1'b0;
          count_d      = '0;
        end
      end
    end else if (!in_payload_q) begin
      want_push = 1'b1;
      case (in_i.rx_byte)
        RxAck:   blk = last_block_q + BlkBits'(1);
        RxNak:   blk = last_block_q;
        default: blk = '0;
      endcase
      if (in_i.rx_byte == RxAck && !blk_in_file(last_block_q, file_size_i)) begin
        job_o.kind = JOB_FINISH;
      end else begin
        last_block_d = blk;
        if (blk_in_file(blk, file_size_i)) begin
          job_o.kind     = JOB_HEADER;
          job_o.byte_val = blk[7:0] + 8'd1;
          job_o.blk      = blk;
          in_payload_d   = 1'b1;
          count_d        = '0;
          crc_d          = '0;
        end else begin
          job_o.kind = JOB_EOT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_block_q <= '0;
      crc_q        <= '0;
      count_q      <= '0;
      in_payload_q <= 1'b0;
    end else if (accept) begin
      last_block_q <= last_block_d;
      crc_q        <= crc_d;
      count_q      <= count_d;
      in_payload_q <= in_payload_d;
    end
  end

endmodule
`default_nettype wire

[rtl/xcs_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcs_queue
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
module xcs_queue import xcs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_data_i,
  output      logic full_o,
  input  wire logic pop_i,
  output      job_t pop_data_o,
  output      logic empty_o
);

  localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntBits = $clog2(QueueDepth + 1);

  job_t               mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign full_o     = count_q == CntBits'(QueueDepth);
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntBits'(1);
      2'b01:   count_d = count_q - CntBits'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

[rtl/xcs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcs_back
// expands queued jobs into result items, one item per cycle while jobs wait and the output is ready
// ----------------------------------------------------------------------------
module xcs_back import xcs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic queue_empty_i,
  input  wire job_t job_i,
  output      logic pop_o,
  xcs_out_if.source out_o
);

  job_t       cur_q;
  logic       busy_q, busy_d;
  logic [1:0] beat_q, beat_d;
  logic       last_beat;
  logic       out_accept;

  always_comb begin
    case (cur_q.kind)
      JOB_ECHO_CRC, JOB_HEADER: last_beat = beat_q == 2'd2;
      default:                  last_beat = 1'b1;
    endcase
  end

  assign out_accept = out_o.valid && out_o.ready;
  assign pop_o      = !queue_empty_i && (!busy_q || (out_accept && last_beat));

  always_comb begin
    busy_d = busy_q;
    beat_d = beat_q;
    if (pop_o) begin
      busy_d = 1'b1;
      beat_d = '0;
    end else if (out_accept) begin
      if (last_beat) begin
        busy_d = 1'b0;
      end else begin
        beat_d = beat_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      beat_q <= '0;
    end else begin
      busy_q <= busy_d;
      beat_q <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end
  end

  always_comb begin
    out_o.valid         = busy_q;
    out_o.tx_byte       = '0;
    out_o.send          = 1'b1;
    out_o.fetch_request = 1'b0;
    out_o.fetch_block   = '0;
    out_o.finished      = 1'b0;
    out_o.last          = last_beat;
    case (cur_q.kind)
      JOB_ECHO: out_o.tx_byte = cur_q.byte_val;
      JOB_ECHO_CRC: begin
        case (beat_q)
          2'd0:    out_o.tx_byte = cur_q.byte_val;
          2'd1:    out_o.tx_byte = cur_q.crc[15:8];
          default: out_o.tx_byte = cur_q.crc[7:0];
        endcase
      end
      JOB_FINISH: begin
        out_o.send     = 1'b0;
        out_o.finished = 1'b1;
      end
      JOB_HEADER: begin
        case (beat_q)
          2'd0:    out_o.tx_byte = TxSoh;
          2'd1:    out_o.tx_byte = cur_q.byte_val;
          default: begin
            out_o.tx_byte       = ~cur_q.byte_val;
            out_o.fetch_request = 1'b1;
            out_o.fetch_block   = cur_q.blk;
          end
        endcase
      end
      JOB_EOT: out_o.tx_byte = TxEot;
      default: out_o.send = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/xmodem_crc_sender.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xmodem_crc_sender
// sender side of xmodem-crc with 128-byte blocks
// ----------------------------------------------------------------------------
// The block takes one input item per clock whenever its job queue has room
// (four entries). An item is either a byte from the receiver (mode 0) or a
// payload byte from the host (mode 1). The front part decodes the item and
// updates the session state (current block, running crc-16, payload count)
// in the cycle it is accepted, then queues at most one job. The back part
// turns each job into one or three result items and presents one result
// per cycle on the output channel while its ready is high, so throughput
// is bound by the output side. The first result of an item appears once
// its job has passed the queue entry and the back part's job register.
// Items that cause no result (receiver bytes mid-payload, payload bytes
// while idle) queue nothing. file_size is written through cfg_we_i/
// cfg_wdata_i and should only change while the block is idle.
// ----------------------------------------------------------------------------
module xmodem_crc_sender import xcs_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [SizeBits-1:0] cfg_wdata_i,
  xcs_in_if.sink                   in_i,
  xcs_out_if.source                out_o
);

  // file length register
  logic [SizeBits-1:0] file_size_q;

  // front to queue
  logic push;
  job_t push_job;
  logic queue_full;

  // queue to back
  logic pop;
  job_t pop_job;
  logic queue_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
    end else if (cfg_we_i) begin
      file_size_q <= cfg_wdata_i;
    end
  end

  // decode items and track block, crc and payload progress
  xcs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .file_size_i  (file_size_q),
    .in_i         (in_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  // decouples input acceptance from output stalls
  xcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (queue_full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (queue_empty)
  );

  // sequence the result items of each job
  xcs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (queue_empty),
    .job_i         (pop_job),
    .pop_o         (pop),
    .out_o         (out_o)
  );

endmodule
`default_nettype wire

[bench/tb_xmodem_crc_sender.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xmodem_crc_sender
// self-checking bench for the xmodem-crc sender: a short stimulus table
// followed by random receiver codes, payload bytes and file size changes;
// every result item is checked field by field against a local predictor
// or, for typed table rows, against the result given in the table
module tb_xmodem_crc_sender;
  import xcs_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 8;
  localparam int DrainCycles  = 16;
  localparam int TotalItems   = 160;
  // stretch of input items with no idling on either side
  localparam int CalmFrom     = 60;
  localparam int CalmTo       = 120;

  // one result item as it leaves the block
  typedef struct packed {
    logic [7:0]         tx_byte;
    logic               send;
    logic               fetch_request;
    logic [BlkBits-1:0] fetch_block;
    logic               finished;
    logic               last;
  } link_res_t;

  // stimulus table: predicted rows, rows with a typed result or with none, size writes
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NONE,
    ROW_ONE,
    ROW_SIZE
  } row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic               mode;
    logic [7:0]         rx;
    logic [7:0]         db;
    logic [SizeBits-1:0] size;
    link_res_t          res;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [SizeBits-1:0] cfg_wdata_i;

  xcs_in_if  in_if();
  xcs_out_if out_if();

  xmodem_crc_sender DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // session state of the predictor, all zero after reset
  logic [SizeBits-1:0] m_file_size = '0;
  logic [BlkBits-1:0]  m_last_blk  = '0;
  logic [15:0]         m_crc       = '0;
  logic [7:0]          m_count     = '0;
  logic                m_in_payload = 1'b0;

  link_res_t link_expect_q[$];
  dir_row_t  dir_rows[$];

  logic calm = 1'b0;   // no idling on either side while set
  int   cycle_count    = 0;
  int   errors         = 0;
  int   items_in       = 0;
  int   work_items     = 0;
  int   results_seen   = 0;
  int   blocks_fetched = 0;
  int   size_writes    = 0;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic link_res_t link_res(input logic [7:0] tx, input logic snd,
                                         input logic fr, input logic [BlkBits-1:0] blk,
                                         input logic fin, input logic lst);
    link_res_t r;
    r.tx_byte       = tx;
    r.send          = snd;
    r.fetch_request = fr;
    r.fetch_block   = blk;
    r.finished      = fin;
    r.last          = lst;
    return r;
  endfunction

  // crc-16/xmodem, one data bit at a time from the msb
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  function automatic logic block_in_range(input logic [BlkBits-1:0] blk);
    logic [31:0] offs;
    offs = 32'(blk) << 7;
    return offs < 32'(m_file_size);
  endfunction

  // advance the session by one accepted item, queue its results, return their count
  function automatic int predict_sender(input logic mode, input logic [7:0] rx,
                                        input logic [7:0] db);
    logic [BlkBits-1:0] blk;
    logic [7:0]         cnt;
    if (mode == ModeData) begin
      // payload byte while idle is dropped
      if (!m_in_payload) return 0;
      m_crc   = crc16_update(m_crc, db);
      m_count = m_count + 8'd1;
      if (m_count < 8'd128) begin
        link_expect_q.push_back(link_res(db, 1'b1, 1'b0, '0, 1'b0, 1'b1));
        return 1;
      end
      // closing byte, then the crc high byte first
      link_expect_q.push_back(link_res(db, 1'b1, 1'b0, '0, 1'b0, 1'b0));
      link_expect_q.push_back(link_res(m_crc[15:8], 1'b1, 1'b0, '0, 1'b0, 1'b0));
      link_expect_q.push_back(link_res(m_crc[7:0], 1'b1, 1'b0, '0, 1'b0, 1'b1));
      m_in_payload = 1'b0;
      m_count      = '0;
      return 3;
    end
    // receiver byte mid-payload is dropped
    if (m_in_payload) return 0;
    if (rx == RxAck) begin
      if (!block_in_range(m_last_blk)) begin
        // ack after the end: session done, block stays
        link_expect_q.push_back(link_res(8'h00, 1'b0, 1'b0, '0, 1'b1, 1'b1));
        return 1;
      end
      blk = m_last_blk + 1'b1;
    end else if (rx == RxNak) begin
      blk = m_last_blk;
    end else begin
      // start code or anything unknown restarts the file
      blk = '0;
    end
    m_last_blk = blk;
    if (block_in_range(blk)) begin
      cnt = 8'(blk + 1'b1);
      link_expect_q.push_back(link_res(TxSoh, 1'b1, 1'b0, '0, 1'b0, 1'b0));
      link_expect_q.push_back(link_res(cnt, 1'b1, 1'b0, '0, 1'b0, 1'b0));
      link_expect_q.push_back(link_res(~cnt, 1'b1, 1'b1, blk, 1'b0, 1'b1));
      m_in_payload = 1'b1;
      m_count      = '0;
      m_crc        = '0;
      blocks_fetched++;
      return 3;
    end
    link_expect_q.push_back(link_res(TxEot, 1'b1, 1'b0, '0, 1'b0, 1'b1));
    return 1;
  endfunction

  // present one item from the falling edge, hold it until the block takes it
  task automatic send_and_predict(input logic mode, input logic [7:0] rx,
                                  input logic [7:0] db, output int n);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 20) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= mode;
    in_if.rx_byte   <= rx;
    in_if.data_byte <= db;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    // accepted at this edge
    n = predict_sender(mode, rx, db);
    items_in++;
    if (n > 0) work_items++;
  endtask

  task automatic send_rx(input logic [7:0] rx);
    int n;
    send_and_predict(ModeRx, rx, 8'($urandom), n);
  endtask

  // file size changes only with nothing in flight
  task automatic write_file_size(input logic [SizeBits-1:0] size);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (link_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    m_file_size = size;
    size_writes++;
  endtask

  function automatic logic [SizeBits-1:0] pick_file_size();
    int r;
    r = $urandom_range(99);
    if (r < 55) return SizeBits'($urandom_range(300));
    if (r < 70) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return SizeBits'(1);
        2:       return SizeBits'(128);
        default: return SizeBits'(129);
      endcase
    end
    if (r < 85) return '1;
    return SizeBits'($urandom);
  endfunction

  // one random step: payload bytes, now and then a receiver byte, while a block
  // is open, otherwise receiver codes, stray payload bytes and now and then a new file size
  task automatic send_random_item();
    int r;
    int n;
    r = $urandom_range(99);
    if (m_in_payload) begin
      if (r < 4) send_and_predict(ModeRx, 8'($urandom), 8'($urandom), n);
      else       send_and_predict(ModeData, 8'($urandom), 8'($urandom), n);
    end else begin
      if ($urandom_range(99) < 10) write_file_size(pick_file_size());
      if (r < 35)      send_rx(RxAck);
      else if (r < 50) send_rx(RxNak);
      else if (r < 65) send_rx(RxStart);
      else if (r < 85) send_rx(8'($urandom));
      else             send_and_predict(ModeData, 8'($urandom), 8'($urandom), n);
    end
  endtask

  task automatic add_row(input row_kind_e kind, input logic mode, input logic [7:0] rx,
                         input logic [7:0] db, input logic [SizeBits-1:0] size,
                         input link_res_t res);
    dir_row_t row;
    row.kind = kind;
    row.mode = mode;
    row.rx   = rx;
    row.db   = db;
    row.size = size;
    row.res  = res;
    dir_rows.push_back(row);
  endtask

  // result side: random back-pressure from the falling edge
  always @(negedge clk_i) out_if.ready <= calm || ($urandom_range(99) >= 20);

  // compare every accepted result item with the oldest expectation
  always @(posedge clk_i) begin : check_results
    link_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (link_expect_q.size() == 0) begin
        $error("result item with nothing expected: tx_byte %0h", out_if.tx_byte);
        errors++;
      end else begin
        want = link_expect_q.pop_front();
        if (out_if.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %0h, got %0h", want.tx_byte, out_if.tx_byte);
          errors++;
        end
        if (out_if.send !== want.send) begin
          $error("send: expected %0b, got %0b", want.send, out_if.send);
          errors++;
        end
        if (out_if.fetch_request !== want.fetch_request) begin
          $error("fetch_request: expected %0b, got %0b", want.fetch_request,
                 out_if.fetch_request);
          errors++;
        end
        if (out_if.fetch_block !== want.fetch_block) begin
          $error("fetch_block: expected %0d, got %0d", want.fetch_block, out_if.fetch_block);
          errors++;
        end
        if (out_if.finished !== want.finished) begin
          $error("finished: expected %0b, got %0b", want.finished, out_if.finished);
          errors++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_if.last);
          errors++;
        end
      end
    end
  end

  // hung handshake or lost result
  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("tb_xmodem_crc_sender: done, errors");
    $finish;
  end

  initial begin : stimulus
    link_res_t eot;
    link_res_t fin;
    link_res_t none;
    int        n;
    int        directed_items;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_if.valid     = 1'b0;
    in_if.mode      = ModeRx;
    in_if.rx_byte   = '0;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;

    eot  = link_res(TxEot, 1'b1, 1'b0, '0, 1'b0, 1'b1);
    fin  = link_res(8'h00, 1'b0, 1'b0, '0, 1'b1, 1'b1);
    none = '0;

    // straight out of reset the file is empty
    add_row(ROW_NONE, ModeData, 8'h00, 8'hFF, '0, none);   // payload byte while idle
    add_row(ROW_ONE,  ModeRx,   RxStart, 8'h00, '0, eot);
    add_row(ROW_ONE,  ModeRx,   RxAck,   8'hFF, '0, fin);   // ack past the end
    add_row(ROW_ONE,  ModeRx,   RxNak,   8'h00, '0, eot);
    add_row(ROW_ONE,  ModeRx,   8'hFF,   8'hFF, '0, eot);   // unknown codes restart
    add_row(ROW_ONE,  ModeRx,   8'h00,   8'h00, '0, eot);
    add_row(ROW_SIZE, ModeRx,   8'h00,   8'h00, '0, none);
    add_row(ROW_ONE,  ModeRx,   RxAck,   8'h00, '0, fin);
    // largest file: a data block opens, receiver bytes inside it are dropped
    add_row(ROW_SIZE,    ModeRx,   8'h00,   8'h00, '1, none);
    add_row(ROW_PREDICT, ModeRx,   RxStart, 8'h5A, '0, none);
    add_row(ROW_NONE,    ModeRx,   RxAck,   8'h00, '0, none);
    add_row(ROW_NONE,    ModeRx,   RxNak,   8'hFF, '0, none);
    add_row(ROW_NONE,    ModeRx,   RxStart, 8'h00, '0, none);
    add_row(ROW_NONE,    ModeRx,   8'hFF,   8'hFF, '0, none);
    add_row(ROW_PREDICT, ModeData, 8'hFF,   8'h00, '0, none);
    add_row(ROW_PREDICT, ModeData, 8'h00,   8'hFF, '0, none);
    add_row(ROW_PREDICT, ModeData, 8'hAA,   8'h55, '0, none);
    add_row(ROW_PREDICT, ModeData, 8'h55,   8'hAA, '0, none);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_SIZE) begin
        write_file_size(dir_rows[i].size);
      end else begin
        send_and_predict(dir_rows[i].mode, dir_rows[i].rx, dir_rows[i].db, n);
        // typed rows replace what the predictor queued
        if (dir_rows[i].kind != ROW_PREDICT) begin
          repeat (n) void'(link_expect_q.pop_back());
          if (dir_rows[i].kind == ROW_ONE) link_expect_q.push_back(dir_rows[i].res);
        end
      end
    end
    directed_items = items_in;

    // random part, the open block from the table is finished first
    while (items_in < TotalItems) begin
      calm = (items_in >= CalmFrom && items_in < CalmTo);
      send_random_item();
    end
    calm = 1'b0;

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (link_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d input items (%0d from the table, %0d with results), %0d results",
             items_in, directed_items, work_items, results_seen);
    $display("%0d data blocks fetched, %0d file size writes, %0d cycles",
             blocks_fetched, size_writes, cycle_count);
    if (errors == 0 && link_expect_q.size() == 0) begin
      $display("tb_xmodem_crc_sender: done, clean");
    end else begin
      $display("tb_xmodem_crc_sender: done, errors");
    end
    $finish;
  end

endmodule
